@@ sv/gvn_pkg.sv @@
// ----------------------------------------------------------------------------
// gvn_pkg: shared types and constants of the grid vertex normal generator
// Vertex, normal and control types used by the core and the normal engine.
// ----------------------------------------------------------------------------
`default_nettype none

package gvn_pkg;

    localparam int POS_W  = 24;   // Q8.16 position component
    localparam int DIFF_W = 25;   // exact edge component
    localparam int NRM_W  = 16;   // Q1.14 normal component
    localparam int TEX_W  = 17;   // Q1.16 texture coordinate up to 1.0
    localparam int DIM_W  = 13;   // grid dimension up to 4096
    localparam int VTX_W  = 3 * POS_W;

    localparam logic [14:0] UNIT_ONE = 15'd16384;
    localparam logic [16:0] TEX_ONE  = 17'd65536;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } vtx_t;

    typedef struct packed {
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nz;
    } nrm_vec_t;

    // request to the normal engine
    typedef struct packed {
        logic start;
        logic flip;
    } nrm_ctl_t;

endpackage

`default_nettype wire

@@ sv/gvn_ram.sv @@
// ----------------------------------------------------------------------------
// gvn_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gvn_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ sv/gvn_norm.sv @@
// ----------------------------------------------------------------------------
// gvn_norm: iterative normal engine
// Builds two unit edge vectors with one shared subtractor (square root and
// division steps) and one shared multiplier, then forms their cross product.
// ----------------------------------------------------------------------------
`default_nettype none

module gvn_norm (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire gvn_pkg::nrm_ctl_t ctl,
    input  wire gvn_pkg::vtx_t     p_vtx,
    input  wire gvn_pkg::vtx_t     h_vtx,
    input  wire gvn_pkg::vtx_t     v_vtx,
    output logic                   done,
    output gvn_pkg::nrm_vec_t      nrm
);
    import gvn_pkg::*;

    localparam logic [3:0] N_IDLE  = 4'd0;
    localparam logic [3:0] N_DIFF  = 4'd1;
    localparam logic [3:0] N_SQ    = 4'd2;
    localparam logic [3:0] N_ROOT  = 4'd3;
    localparam logic [3:0] N_DSET  = 4'd4;
    localparam logic [3:0] N_DIV   = 4'd5;
    localparam logic [3:0] N_DSTO  = 4'd6;
    localparam logic [3:0] N_CROSS = 4'd7;
    localparam logic [3:0] N_DONE  = 4'd8;

    localparam int ACC_W = 51;
    localparam int SUB_W = 46;

    logic [3:0]  st_reg;
    logic        edge_reg;
    logic [1:0]  k_reg;
    logic [4:0]  cnt_reg;
    logic        flip_reg;

    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [NRM_W-1:0]  a0_reg, a1_reg, a2_reg, b0_reg, b1_reg, b2_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [61:0]              rad_reg;
    logic [30:0]              root_reg;
    logic [32:0]              rem_reg;
    logic [SUB_W-1:0]         num_reg;
    logic [44:0]              dsh_reg;
    logic [14:0]              quo_reg;
    nrm_vec_t                 nrm_reg;

    vtx_t                     e_vtx;
    logic signed [DIFF_W-1:0] dk;
    logic [DIFF_W-1:0]        dk_mag;
    logic                     d_zero;

    logic signed [DIFF_W-1:0]   mul_a, mul_b;
    logic signed [2*DIFF_W-1:0] mul_p;
    logic                       mul_neg;
    logic signed [ACC_W-1:0]    acc_sum;

    logic [34:0]      root_cand;
    logic [SUB_W-1:0] sub_a, sub_b;
    logic [SUB_W:0]   sub_d;
    logic             sub_ge;

    logic [14:0]             quo_fin;
    logic [14:0]             quo_clamp;
    logic signed [NRM_W-1:0] unit_val;

    logic [ACC_W-1:0]        crs_mag;
    logic [ACC_W-1:0]        crs_rnd;
    logic [14:0]             crs_q;
    logic                    crs_neg;
    logic signed [NRM_W-1:0] crs_val;

    // edge endpoint and selected component
    assign e_vtx  = edge_reg ? v_vtx : h_vtx;
    assign d_zero = (dx_reg == '0) && (dy_reg == '0) && (dz_reg == '0);

    always_comb begin
        case (k_reg)
            2'd0:    dk = dx_reg;
            2'd1:    dk = dy_reg;
            default: dk = dz_reg;
        endcase
    end
    assign dk_mag = dk[DIFF_W-1] ? DIFF_W'(-dk) : DIFF_W'(dk);

    // shared multiplier: squares of edge components, then cross terms
    always_comb begin
        mul_a   = dk;
        mul_b   = dk;
        mul_neg = 1'b0;
        if (st_reg == N_CROSS) begin
            mul_neg = cnt_reg[0];
            case (cnt_reg[2:0])
                3'd0:    begin mul_a = DIFF_W'(a1_reg); mul_b = DIFF_W'(b2_reg); end
                3'd1:    begin mul_a = DIFF_W'(a2_reg); mul_b = DIFF_W'(b1_reg); end
                3'd2:    begin mul_a = DIFF_W'(a2_reg); mul_b = DIFF_W'(b0_reg); end
                3'd3:    begin mul_a = DIFF_W'(a0_reg); mul_b = DIFF_W'(b2_reg); end
                3'd4:    begin mul_a = DIFF_W'(a0_reg); mul_b = DIFF_W'(b1_reg); end
                default: begin mul_a = DIFF_W'(a1_reg); mul_b = DIFF_W'(b0_reg); end
            endcase
        end
    end
    assign mul_p   = mul_a * mul_b;
    assign acc_sum = mul_neg ? acc_reg - ACC_W'(mul_p) : acc_reg + ACC_W'(mul_p);

    // shared subtractor: square root digit or division bit
    assign root_cand = {rem_reg, rad_reg[61:60]};
    always_comb begin
        if (st_reg == N_ROOT) begin
            sub_a = SUB_W'(root_cand);
            sub_b = SUB_W'({root_reg, 2'b01});
        end else begin
            sub_a = num_reg;
            sub_b = SUB_W'(dsh_reg);
        end
    end
    assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge = ~sub_d[SUB_W];

    // unit component: clamp quotient, restore sign
    assign quo_fin   = quo_reg;
    assign quo_clamp = (quo_fin > UNIT_ONE) ? UNIT_ONE : quo_fin;
    assign unit_val  = dk[DIFF_W-1] ? -$signed({1'b0, quo_clamp}) : $signed({1'b0, quo_clamp});

    // cross term to Q1.14, rounded half away from zero, sign set by flip
    assign crs_mag = acc_sum[ACC_W-1] ? ACC_W'(-acc_sum) : ACC_W'(acc_sum);
    assign crs_rnd = crs_mag + ACC_W'(8192);
    assign crs_q   = (crs_rnd[ACC_W-1:14] > ACC_W'(UNIT_ONE)) ? UNIT_ONE : crs_rnd[28:14];
    assign crs_neg = flip_reg ? acc_sum[ACC_W-1] : ~acc_sum[ACC_W-1];
    assign crs_val = crs_neg ? -$signed({1'b0, crs_q}) : $signed({1'b0, crs_q});

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= N_IDLE;
            edge_reg <= 1'b0;
            k_reg    <= 2'd0;
            cnt_reg  <= 5'd0;
        end else begin
            case (st_reg)
                N_IDLE: begin
                    if (ctl.start) begin
                        flip_reg <= ctl.flip;
                        edge_reg <= 1'b0;
                        st_reg   <= N_DIFF;
                    end
                end
                N_DIFF: begin
                    dx_reg  <= DIFF_W'(e_vtx.x) - DIFF_W'(p_vtx.x);
                    dy_reg  <= DIFF_W'(e_vtx.y) - DIFF_W'(p_vtx.y);
                    dz_reg  <= DIFF_W'(e_vtx.z) - DIFF_W'(p_vtx.z);
                    acc_reg <= '0;
                    k_reg   <= 2'd0;
                    st_reg  <= N_SQ;
                end
                N_SQ: begin
                    acc_reg <= acc_sum;
                    k_reg   <= k_reg + 2'd1;
                    if (k_reg == 2'd2) begin
                        k_reg <= 2'd0;
                        if (d_zero) begin
                            // zero-length edge: unit vector is zero
                            if (!edge_reg) begin
                                a0_reg <= '0; a1_reg <= '0; a2_reg <= '0;
                                edge_reg <= 1'b1;
                                st_reg   <= N_DIFF;
                            end else begin
                                b0_reg <= '0; b1_reg <= '0; b2_reg <= '0;
                                acc_reg <= '0;
                                cnt_reg <= 5'd0;
                                st_reg  <= N_CROSS;
                            end
                        end else begin
                            rad_reg  <= {acc_sum[49:0], 12'd0};
                            root_reg <= '0;
                            rem_reg  <= '0;
                            cnt_reg  <= 5'd30;
                            st_reg   <= N_ROOT;
                        end
                    end
                end
                N_ROOT: begin
                    rem_reg  <= sub_ge ? sub_d[32:0] : root_cand[32:0];
                    root_reg <= {root_reg[29:0], sub_ge};
                    rad_reg  <= {rad_reg[59:0], 2'b00};
                    cnt_reg  <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0) begin
                        st_reg <= N_DSET;
                    end
                end
                N_DSET: begin
                    num_reg <= SUB_W'({dk_mag, 20'd0}) + SUB_W'(root_reg[30:1]);
                    dsh_reg <= {root_reg, 14'd0};
                    quo_reg <= '0;
                    cnt_reg <= 5'd14;
                    st_reg  <= N_DIV;
                end
                N_DIV: begin
                    if (sub_ge) begin
                        num_reg <= sub_d[SUB_W-1:0];
                    end
                    quo_reg <= {quo_reg[13:0], sub_ge};
                    dsh_reg <= {1'b0, dsh_reg[44:1]};
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0) begin
                        st_reg <= N_DSTO;
                    end
                end
                N_DSTO: begin
                    case ({edge_reg, k_reg})
                        3'b000:  a0_reg <= unit_val;
                        3'b001:  a1_reg <= unit_val;
                        3'b010:  a2_reg <= unit_val;
                        3'b100:  b0_reg <= unit_val;
                        3'b101:  b1_reg <= unit_val;
                        default: b2_reg <= unit_val;
                    endcase
                    k_reg  <= k_reg + 2'd1;
                    st_reg <= N_DSET;
                    if (k_reg == 2'd2) begin
                        k_reg <= 2'd0;
                        if (!edge_reg) begin
                            edge_reg <= 1'b1;
                            st_reg   <= N_DIFF;
                        end else begin
                            acc_reg <= '0;
                            cnt_reg <= 5'd0;
                            st_reg  <= N_CROSS;
                        end
                    end
                end
                N_CROSS: begin
                    acc_reg <= acc_sum;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg[0]) begin
                        acc_reg <= '0;
                        case (cnt_reg[2:1])
                            2'd0:    nrm_reg.nx <= crs_val;
                            2'd1:    nrm_reg.ny <= crs_val;
                            default: nrm_reg.nz <= crs_val;
                        endcase
                    end
                    if (cnt_reg == 5'd5) begin
                        st_reg <= N_DONE;
                    end
                end
                N_DONE: begin
                    st_reg <= N_IDLE;
                end
                default: begin
                    st_reg <= N_IDLE;
                end
            endcase
        end
    end

    assign done = (st_reg == N_DONE);
    assign nrm  = nrm_reg;

endmodule

`default_nettype wire

@@ sv/grid_vertex_normal_gen_core.sv @@
// ----------------------------------------------------------------------------
// grid_vertex_normal_gen_core: per-vertex records for a regular grid mesh
// Takes vertex positions in raster order and emits position, unit normal and
// texture coordinates for each vertex once its neighbours have arrived.
// ----------------------------------------------------------------------------
// Usage:
//   s_* : one vertex position per transaction, s_tdata = {z, y, x}.
//   m_* : up to three records per input vertex; m_tuser marks the last
//         record caused by that input, m_tlast the final vertex of the grid.
//   APB : grid_width, grid_height, u_step, v_step at byte addresses 0,4,8,12.
//         Writing a grid dimension restarts the frame.
// Timing: one input at a time. An input that causes no record (first row)
//   reads the line store and finishes without the normal engine. Each
//   record is built in the iterative normal engine: per edge 31 square-root
//   steps and three 15-step divisions on one shared subtractor, then the
//   multiplies of the cross product. A record held on a stalled m_tready holds the block.
// Reset: counters return to the start of a frame and registers to 16, 16,
//   4096, 4096. The line store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_vertex_normal_gen_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input vertex
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [71:0]  s_tdata,   // in_x[23:0], in_y[47:24], in_z[71:48]
    // output record
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [175:0]      m_tdata,   // vertex_number, out_x, out_y, out_z,
                                         // normal_x, normal_y, normal_z,
                                         // tex_u, tex_v, zero fill
    output logic              m_tuser,   // end_of_run
    output logic              m_tlast,   // end_of_frame
    // configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import gvn_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    localparam logic [1:0] REG_GRID_W = 2'd0;
    localparam logic [1:0] REG_GRID_H = 2'd1;
    localparam logic [1:0] REG_U_STEP = 2'd2;
    localparam logic [1:0] REG_V_STEP = 2'd3;

    localparam logic [1:0] REC_ABOVE = 2'd0;
    localparam logic [1:0] REC_LEFT  = 2'd1;
    localparam logic [1:0] REC_SELF  = 2'd2;

    localparam logic [2:0] T_IDLE   = 3'd0;
    localparam logic [2:0] T_RDN    = 3'd1;
    localparam logic [2:0] T_RDW    = 3'd2;
    localparam logic [2:0] T_NSTART = 3'd3;
    localparam logic [2:0] T_NWAIT  = 3'd4;
    localparam logic [2:0] T_OUT    = 3'd5;
    localparam logic [2:0] T_FIN    = 3'd6;

    logic [8:0]  gw_reg, gh_reg;
    logic [15:0] us_reg, vs_reg;
    logic        cfg_we;

    logic [2:0]    st_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [1:0]    k_reg;
    vtx_t          cur_reg, above_reg, right_reg, prev_reg, evict_reg;

    logic [DIM_W-1:0] gw_ext, gh_ext, w_eff, h_eff;
    logic             last_col, last_row, has0, has1, has2;
    logic             rec_more;
    logic [1:0]       rec_next;

    logic [DIM_W-1:0] rec_col, rec_row;
    vtx_t             rec_p, rec_h, rec_v;
    logic             rec_flip, rec_eof;

    logic [DIM_W-1:0]   col1, row1;
    logic [28:0]        tu_p, tv_p;
    logic [2*DIM_W-1:0] vn_p;

    logic [15:0]     vnum_reg;
    logic [16:0]     tu_reg, tv_reg;
    vtx_t            opos_reg;
    nrm_vec_t        onrm_reg;
    logic            eor_reg, eof_reg;

    logic [CW-1:0]   ram_raddr;
    logic [VTX_W-1:0] ram_rdata;
    nrm_ctl_t        n_ctl;
    logic            n_done;
    nrm_vec_t        n_vec;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_GRID_W: prdata = 32'(gw_reg);
            REG_GRID_H: prdata = 32'(gh_reg);
            REG_U_STEP: prdata = 32'(us_reg);
            default:    prdata = 32'(vs_reg);
        endcase
    end

    // effective grid size, clamped
    assign gw_ext = DIM_W'(gw_reg);
    assign gh_ext = DIM_W'(gh_reg);
    always_comb begin
        if (gw_ext < DIM_W'(2))              w_eff = DIM_W'(2);
        else if (gw_ext > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
        else                                 w_eff = gw_ext;
        if (gh_ext < DIM_W'(2))               h_eff = DIM_W'(2);
        else if (gh_ext > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
        else                                  h_eff = gh_ext;
    end

    assign last_col = (DIM_W'(col_reg) == w_eff - DIM_W'(1));
    assign last_row = (DIM_W'(row_reg) == h_eff - DIM_W'(1));
    assign has0     = (row_reg != '0);
    assign has1     = last_row && (col_reg != '0);
    assign has2     = last_row && last_col;

    // which record follows the current one
    always_comb begin
        rec_more = 1'b0;
        rec_next = REC_SELF;
        case (k_reg)
            REC_ABOVE: begin
                rec_more = has1 | has2;
                rec_next = has1 ? REC_LEFT : REC_SELF;
            end
            REC_LEFT: begin
                rec_more = has2;
                rec_next = REC_SELF;
            end
            default: begin
                rec_more = 1'b0;
                rec_next = REC_SELF;
            end
        endcase
    end

    // operands of the current record
    always_comb begin
        case (k_reg)
            REC_ABOVE: begin
                rec_col  = DIM_W'(col_reg);
                rec_row  = DIM_W'(row_reg) - DIM_W'(1);
                rec_p    = above_reg;
                rec_h    = last_col ? evict_reg : right_reg;
                rec_v    = cur_reg;
                rec_flip = last_col;
                rec_eof  = 1'b0;
            end
            REC_LEFT: begin
                rec_col  = DIM_W'(col_reg) - DIM_W'(1);
                rec_row  = DIM_W'(row_reg);
                rec_p    = prev_reg;
                rec_h    = cur_reg;
                rec_v    = evict_reg;
                rec_flip = 1'b1;
                rec_eof  = 1'b0;
            end
            default: begin
                rec_col  = DIM_W'(col_reg);
                rec_row  = DIM_W'(row_reg);
                rec_p    = cur_reg;
                rec_h    = prev_reg;
                rec_v    = above_reg;
                rec_flip = 1'b0;
                rec_eof  = 1'b1;
            end
        endcase
    end

    // index and texture coordinates
    assign col1 = rec_col + DIM_W'(1);
    assign row1 = rec_row + DIM_W'(1);
    assign tu_p = 29'(col1) * 29'(us_reg);
    assign tv_p = 29'(row1) * 29'(vs_reg);
    assign vn_p = (2*DIM_W)'(rec_row) * (2*DIM_W)'(w_eff) + (2*DIM_W)'(rec_col);

    // line store
    assign ram_raddr = (st_reg == T_RDN) ? col_reg + CW'(1) : col_reg;

    gvn_ram #(
        .WIDTH (VTX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .aclk  (aclk),
        .we    (st_reg == T_RDW),
        .waddr (col_reg),
        .wdata (cur_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // normal engine
    assign n_ctl.start = (st_reg == T_NSTART);
    assign n_ctl.flip  = rec_flip;

    gvn_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (n_ctl),
        .p_vtx   (rec_p),
        .h_vtx   (rec_h),
        .v_vtx   (rec_v),
        .done    (n_done),
        .nrm     (n_vec)
    );

    // sequencer, counters and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= T_IDLE;
            col_reg <= '0;
            row_reg <= '0;
            k_reg   <= REC_ABOVE;
            gw_reg  <= 9'd16;
            gh_reg  <= 9'd16;
            us_reg  <= 16'd4096;
            vs_reg  <= 16'd4096;
        end else begin
            case (st_reg)
                T_IDLE: begin
                    if (s_tvalid) begin
                        cur_reg.x <= s_tdata[23:0];
                        cur_reg.y <= s_tdata[47:24];
                        cur_reg.z <= s_tdata[71:48];
                        st_reg    <= T_RDN;
                    end
                end
                T_RDN: begin
                    above_reg <= ram_rdata;
                    st_reg    <= T_RDW;
                end
                T_RDW: begin
                    right_reg <= ram_rdata;
                    k_reg     <= REC_ABOVE;
                    st_reg    <= has0 ? T_NSTART : T_FIN;
                end
                T_NSTART: begin
                    vnum_reg <= vn_p[15:0];
                    tu_reg   <= (tu_p > 29'(TEX_ONE)) ? TEX_ONE : tu_p[16:0];
                    tv_reg   <= (tv_p > 29'(TEX_ONE)) ? TEX_ONE : tv_p[16:0];
                    opos_reg <= rec_p;
                    eof_reg  <= rec_eof;
                    eor_reg  <= ~rec_more;
                    st_reg   <= T_NWAIT;
                end
                T_NWAIT: begin
                    if (n_done) begin
                        onrm_reg <= n_vec;
                        st_reg   <= T_OUT;
                    end
                end
                T_OUT: begin
                    if (m_tready) begin
                        k_reg  <= rec_next;
                        st_reg <= rec_more ? T_NSTART : T_FIN;
                    end
                end
                T_FIN: begin
                    // shift history, advance raster position
                    evict_reg <= above_reg;
                    prev_reg  <= cur_reg;
                    if (last_col) begin
                        col_reg <= '0;
                        row_reg <= last_row ? '0 : row_reg + RW'(1);
                    end else begin
                        col_reg <= col_reg + CW'(1);
                    end
                    st_reg <= T_IDLE;
                end
                default: begin
                    st_reg <= T_IDLE;
                end
            endcase

            if (cfg_we) begin
                case (paddr[3:2])
                    REG_GRID_W: begin
                        gw_reg  <= pwdata[8:0];
                        col_reg <= '0;
                        row_reg <= '0;
                    end
                    REG_GRID_H: begin
                        gh_reg  <= pwdata[8:0];
                        col_reg <= '0;
                        row_reg <= '0;
                    end
                    REG_U_STEP: us_reg <= pwdata[15:0];
                    default:    vs_reg <= pwdata[15:0];
                endcase
            end
        end
    end

    // ports
    assign s_tready = (st_reg == T_IDLE);
    assign m_tvalid = (st_reg == T_OUT);
    assign m_tuser  = eor_reg;
    assign m_tlast  = eof_reg;
    assign m_tdata  = {6'd0, tv_reg, tu_reg, onrm_reg.nz, onrm_reg.ny, onrm_reg.nx,
                       opos_reg.z, opos_reg.y, opos_reg.x, vnum_reg};

    // checks
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while a record is pending");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        DIM_W'(col_reg) < w_eff)
        else $error("column counter beyond grid width");

    a_eof_is_eor: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("end of frame without end of run");

    a_run_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tuser) |=> (st_reg == T_FIN))
        else $error("records continue after end of run");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second input taken while one is in work");

endmodule

`default_nettype wire
